// ===== rtl/lac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg
// Shared sizes, codes and sequencer states of the aged Life grid.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = 7;
    localparam int CELL_W   = COL_W + ROW_W;
    localparam int AGE_W    = 16;
    localparam int CLR_W    = 2;
    localparam int OP_W     = 3;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;

    localparam logic [OP_W-1:0] OP_STEP   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [IDX_W-1:0] REG_COLS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROWS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_GREEN = 2'd2;

    localparam logic [CLR_W-1:0] COLOR_WHITE = 2'd0;
    localparam logic [CLR_W-1:0] COLOR_BLACK = 2'd1;
    localparam logic [CLR_W-1:0] COLOR_GREEN = 2'd2;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_STEP_A,
        ST_STEP_B,
        ST_CELL,
        ST_ROW_END,
        ST_ROW_LOAD,
        ST_Q_CUR,
        ST_Q_PREV,
        ST_Q_NXT,
        ST_Q_EVAL,
        ST_EDIT,
        ST_DONE
    } lac_state_t;

endpackage

// ===== rtl/life_automaton_with_cell_age.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_with_cell_age
// Bounded B3/S23 Life grid with a per-cell age and colour store.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_ready is high only while the sequencer
// idles. A step sweeps every cell in use through the single age/colour
// update unit, one cell per cycle with the memory read overlapped. Clear
// runs a pass over all 4096 colour entries. A result waits for the output
// register to drain before the sequencer returns to idle. After reset the
// block clears its stores, all 4096 entries, before s_ready first rises;
// configuration writes are taken throughout.
module life_automaton_with_cell_age (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lac_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lac_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lac_pkg::OP_W-1:0]    s_operation,
    input  logic [lac_pkg::COL_W-1:0]   s_col,
    input  logic [lac_pkg::ROW_W-1:0]   s_row,
    input  logic                        s_new_alive,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_cell_alive,
    output logic                        m_cell_dying,
    output logic [lac_pkg::AGE_W-1:0]   m_cell_age,
    output logic [lac_pkg::CLR_W-1:0]   m_cell_color
);
    import lac_pkg::*;

    // configuration
    logic [CNT_W-1:0] cols_reg, rows_reg;
    logic [AGE_W-1:0] green_reg;
    logic [CNT_W-1:0] nc, nr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= CNT_W'(MAX_COLS);
            rows_reg  <= CNT_W'(MAX_ROWS);
            green_reg <= AGE_W'(200);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLS:  cols_reg  <= cfg_data[CNT_W-1:0];
                REG_ROWS:  rows_reg  <= cfg_data[CNT_W-1:0];
                REG_GREEN: green_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb begin
        nc = (cols_reg == '0) ? CNT_W'(1) :
             (cols_reg > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_reg;
        nr = (rows_reg == '0) ? CNT_W'(1) :
             (rows_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_reg;
    end

    // memories
    logic [MAX_COLS-1:0] alive_mem [MAX_ROWS];
    logic [AGE_W-1:0]    age_mem   [MAX_ROWS*MAX_COLS];
    logic [CLR_W-1:0]    color_mem [MAX_ROWS*MAX_COLS];

    logic                alive_we, alive_re;
    logic [ROW_W-1:0]    alive_waddr, alive_raddr;
    logic [MAX_COLS-1:0] alive_wdata, alive_rdata_reg;
    logic                age_we, color_we, cell_re;
    logic [CELL_W-1:0]   cell_waddr, cell_raddr;
    logic [AGE_W-1:0]    age_wdata, age_rdata_reg;
    logic [CLR_W-1:0]    color_wdata, color_rdata_reg;

    always_ff @(posedge aclk) begin
        if (alive_we) alive_mem[alive_waddr] <= alive_wdata;
        if (alive_re) alive_rdata_reg <= alive_mem[alive_raddr];
    end

    always_ff @(posedge aclk) begin
        if (age_we)   age_mem[cell_waddr]   <= age_wdata;
        if (color_we) color_mem[cell_waddr] <= color_wdata;
        if (cell_re) begin
            age_rdata_reg   <= age_mem[cell_raddr];
            color_rdata_reg <= color_mem[cell_raddr];
        end
    end

    // sequencer registers
    lac_state_t          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                nalive_reg, nalive_next;
    logic                keep_age_reg, keep_age_next;
    logic [CELL_W-1:0]   sweep_reg, sweep_next;
    logic [CNT_W-1:0]    scol_reg, scol_next;
    logic                pend_reg, pend_next;
    logic [COL_W-1:0]    pcol_reg, pcol_next;
    logic [MAX_COLS-1:0] prev_reg, prev_next, cur_reg, cur_next, nxt_reg, nxt_next;
    logic [MAX_COLS-1:0] nrow_reg, nrow_next;
    logic                q_alive_reg, q_alive_next, q_dying_reg, q_dying_next;
    logic [AGE_W-1:0]    q_age_reg, q_age_next;
    logic [CLR_W-1:0]    q_color_reg, q_color_next;
    logic                mv_reg, mv_next;
    logic                ma_reg, ma_next, md_reg, md_next;
    logic [AGE_W-1:0]    mage_reg, mage_next;
    logic [CLR_W-1:0]    mclr_reg, mclr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            keep_age_reg <= 1'b0;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            keep_age_reg <= keep_age_next;
            sweep_reg    <= sweep_next;
            pend_reg     <= pend_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        nalive_reg  <= nalive_next;
        scol_reg    <= scol_next;
        pcol_reg    <= pcol_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        nrow_reg    <= nrow_next;
        q_alive_reg <= q_alive_next;
        q_dying_reg <= q_dying_next;
        q_age_reg   <= q_age_next;
        q_color_reg <= q_color_next;
        ma_reg      <= ma_next;
        md_reg      <= md_next;
        mage_reg    <= mage_next;
        mclr_reg    <= mclr_next;
    end

    // shared cell unit: neighbour count and fate of the cell at pcol_reg
    logic       left_ok, right_ok, self_alive, lives;
    logic [3:0] ncount;
    logic [COL_W-1:0] pcl, pcr;
    logic [AGE_W-1:0] age_inc, age_new;
    logic [CLR_W-1:0] color_new;

    always_comb begin
        pcl      = pcol_reg - COL_W'(1);
        pcr      = pcol_reg + COL_W'(1);
        left_ok  = (pcol_reg != '0);
        right_ok = ({1'b0, pcol_reg} + CNT_W'(1)) < nc;
        self_alive = cur_reg[pcol_reg];
        ncount = 4'(prev_reg[pcol_reg]) + 4'(nxt_reg[pcol_reg])
               + 4'(prev_reg[pcl] & left_ok) + 4'(cur_reg[pcl] & left_ok)
               + 4'(nxt_reg[pcl] & left_ok) + 4'(prev_reg[pcr] & right_ok)
               + 4'(cur_reg[pcr] & right_ok) + 4'(nxt_reg[pcr] & right_ok);
        lives = self_alive ? (ncount == 4'd2 || ncount == 4'd3) : (ncount == 4'd3);
        age_inc = (age_rdata_reg == AGE_MAX) ? age_rdata_reg : age_rdata_reg + AGE_W'(1);
        age_new   = age_rdata_reg;
        color_new = color_rdata_reg;
        if (self_alive) begin
            if (lives) begin
                age_new = age_inc;
                if (age_inc >= green_reg) color_new = COLOR_GREEN;
            end
        end else begin
            if (lives) age_new = '0;
            color_new = COLOR_BLACK;
        end
    end

    // next state and datapath control
    logic in_area, issue;
    logic [CNT_W-1:0] row_p1, row_p2;

    always_comb begin
        in_area = ({1'b0, s_col} < nc) && ({1'b0, s_row} < nr);
        row_p1 = {1'b0, row_reg} + CNT_W'(1);
        row_p2 = {1'b0, row_reg} + CNT_W'(2);
        issue  = scol_reg < nc;

        state_next    = state_reg;
        op_next       = op_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        nalive_next   = nalive_reg;
        keep_age_next = keep_age_reg;
        sweep_next    = sweep_reg;
        scol_next     = scol_reg;
        pend_next     = pend_reg;
        pcol_next     = pcol_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        nrow_next     = nrow_reg;
        q_alive_next  = q_alive_reg;
        q_dying_next  = q_dying_reg;
        q_age_next    = q_age_reg;
        q_color_next  = q_color_reg;
        mv_next       = mv_reg && !m_ready;
        ma_next       = ma_reg;
        md_next       = md_reg;
        mage_next     = mage_reg;
        mclr_next     = mclr_reg;

        alive_we    = 1'b0;
        alive_re    = 1'b0;
        alive_waddr = row_reg;
        alive_raddr = row_reg;
        alive_wdata = nrow_reg;
        age_we      = 1'b0;
        color_we    = 1'b0;
        cell_re     = 1'b0;
        cell_waddr  = {row_reg, pcol_reg};
        cell_raddr  = {row_reg, scol_reg[COL_W-1:0]};
        age_wdata   = age_new;
        color_wdata = color_new;
        s_ready     = 1'b0;

        case (state_reg)
            // clearing pass: colours white, rows dead, ages zero after reset
            ST_SWEEP: begin
                cell_waddr  = sweep_reg;
                color_we    = 1'b1;
                color_wdata = COLOR_WHITE;
                age_we      = !keep_age_reg;
                age_wdata   = '0;
                alive_waddr = sweep_reg[ROW_W-1:0];
                alive_wdata = '0;
                alive_we    = ({1'b0, sweep_reg} < (CELL_W+1)'(MAX_ROWS));
                sweep_next  = sweep_reg + CELL_W'(1);
                if (sweep_reg == '1)
                    state_next = keep_age_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next      = s_operation;
                    row_next     = s_row;
                    col_next     = s_col;
                    nalive_next  = s_new_alive;
                    pcol_next    = s_col;
                    q_alive_next = 1'b0;
                    q_dying_next = 1'b0;
                    q_age_next   = '0;
                    q_color_next = COLOR_WHITE;
                    alive_raddr  = s_row;
                    cell_raddr   = {s_row, s_col};
                    case (s_operation)
                        OP_STEP: begin
                            row_next    = '0;
                            alive_raddr = '0;
                            alive_re    = 1'b1;
                            state_next  = ST_STEP_A;
                        end
                        OP_SET, OP_TOGGLE: begin
                            alive_re   = in_area;
                            state_next = in_area ? ST_EDIT : ST_DONE;
                        end
                        OP_QUERY: begin
                            alive_re   = in_area;
                            cell_re    = in_area;
                            state_next = in_area ? ST_Q_CUR : ST_DONE;
                        end
                        OP_CLEAR: begin
                            keep_age_next = 1'b1;
                            sweep_next    = '0;
                            state_next    = ST_SWEEP;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            // window load for the first row
            ST_STEP_A: begin
                prev_next   = '0;
                cur_next    = alive_rdata_reg;
                nrow_next   = alive_rdata_reg;
                alive_raddr = ROW_W'(1);
                alive_re    = 1'b1;
                state_next  = ST_STEP_B;
            end
            ST_STEP_B: begin
                nxt_next   = (nr > CNT_W'(1)) ? alive_rdata_reg : '0;
                scol_next  = '0;
                pend_next  = 1'b0;
                state_next = ST_CELL;
            end
            // one cell per cycle: read ahead, update the pending one
            ST_CELL: begin
                cell_re   = issue;
                pend_next = issue;
                pcol_next = scol_reg[COL_W-1:0];
                if (issue) scol_next = scol_reg + CNT_W'(1);
                if (pend_reg) begin
                    age_we   = 1'b1;
                    color_we = 1'b1;
                    nrow_next[pcol_reg] = lives;
                end
                if (!issue && !pend_reg) state_next = ST_ROW_END;
            end
            // write the new row back and slide the window
            ST_ROW_END: begin
                alive_we    = 1'b1;
                prev_next   = cur_reg;
                cur_next    = nxt_reg;
                alive_raddr = row_p2[ROW_W-1:0];
                alive_re    = row_p2 < nr;
                if (row_p1 == nr) begin
                    state_next = ST_DONE;
                end else begin
                    row_next   = row_p1[ROW_W-1:0];
                    state_next = ST_ROW_LOAD;
                end
            end
            ST_ROW_LOAD: begin
                nxt_next   = (row_p1 < nr) ? alive_rdata_reg : '0;
                nrow_next  = cur_reg;
                scol_next  = '0;
                pend_next  = 1'b0;
                state_next = ST_CELL;
            end
            // query: gather the three rows around the cell
            ST_Q_CUR: begin
                cur_next    = alive_rdata_reg;
                alive_raddr = row_reg - ROW_W'(1);
                alive_re    = 1'b1;
                state_next  = ST_Q_PREV;
            end
            ST_Q_PREV: begin
                prev_next   = (row_reg != '0) ? alive_rdata_reg : '0;
                alive_raddr = row_p1[ROW_W-1:0];
                alive_re    = 1'b1;
                state_next  = ST_Q_NXT;
            end
            ST_Q_NXT: begin
                nxt_next   = (row_p1 < nr) ? alive_rdata_reg : '0;
                state_next = ST_Q_EVAL;
            end
            ST_Q_EVAL: begin
                q_alive_next = self_alive;
                q_dying_next = !lives;
                q_age_next   = age_rdata_reg;
                q_color_next = color_rdata_reg;
                state_next   = ST_DONE;
            end
            // set or toggle one bit of the addressed row
            ST_EDIT: begin
                alive_wdata = alive_rdata_reg;
                alive_wdata[col_reg] = (op_reg == OP_SET) ? nalive_reg
                                                          : !alive_rdata_reg[col_reg];
                alive_we   = 1'b1;
                state_next = ST_DONE;
            end
            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ma_next    = q_alive_reg;
                    md_next    = q_dying_reg;
                    mage_next  = q_age_reg;
                    mclr_next  = q_color_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid      = mv_reg;
    assign m_cell_alive = ma_reg;
    assign m_cell_dying = md_reg;
    assign m_cell_age   = mage_reg;
    assign m_cell_color = mclr_reg;

endmodule

// ===== rtl/lac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_checker
// Port-level checks of the aged Life grid, bound to the top level.
// ----------------------------------------------------------------------------
module lac_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_cell_alive,
    input logic                        m_cell_dying,
    input logic [lac_pkg::AGE_W-1:0]   m_cell_age,
    input logic [lac_pkg::CLR_W-1:0]   m_cell_color
);
    import lac_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_alive) &&
        $stable(m_cell_dying) && $stable(m_cell_age) && $stable(m_cell_color))
        else $error("stalled result changed");

    // one request at a time: busy straight after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after accept");

    // the clearing pass keeps the input closed after reset
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

    // no result appears in the cycle straight after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

endmodule

bind life_automaton_with_cell_age lac_checker u_lac_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_alive (m_cell_alive),
    .m_cell_dying (m_cell_dying),
    .m_cell_age   (m_cell_age),
    .m_cell_color (m_cell_color)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aged Life grid regression
// Drives set, toggle, query, step, clear and unknown-code requests into the grid with
// random idling on both channels, predicts every result with a cell-level
// model of the grid, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
    import lac_pkg::*;

    localparam int TIMEOUT_CYCLES = 6_000_000;
    localparam logic [OP_W-1:0] OP_BAD = 3'd7;

    typedef struct packed {
        logic             alive;
        logic             dying;
        logic [AGE_W-1:0] age;
        logic [CLR_W-1:0] color;
    } cell_report_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_operation = '0;
    logic [COL_W-1:0]  s_col = '0;
    logic [ROW_W-1:0]  s_row = '0;
    logic              s_new_alive = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_cell_alive;
    logic              m_cell_dying;
    logic [AGE_W-1:0]  m_cell_age;
    logic [CLR_W-1:0]  m_cell_color;

    // grid shadow
    logic              grid_alive [MAX_ROWS][MAX_COLS];
    logic [AGE_W-1:0]  grid_age   [MAX_ROWS][MAX_COLS];
    logic [CLR_W-1:0]  grid_color [MAX_ROWS][MAX_COLS];
    logic [CNT_W-1:0]  width_reg;
    logic [CNT_W-1:0]  height_reg;
    logic [AGE_W-1:0]  green_reg;

    cell_report_t      pending_reports [$];
    int                fail_count;
    int                report_count;
    int                query_count;
    int                cycle_count;
    bit                calm_sink;

    life_automaton_with_cell_age i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("t=%0t timeout", $time);
            $display("life_automaton_with_cell_age regression: fail");
            $finish;
        end
    end

    function automatic int used_cols();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_COLS) return MAX_COLS;
        return width_reg;
    endfunction

    function automatic int used_rows();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_ROWS) return MAX_ROWS;
        return height_reg;
    endfunction

    function automatic bit survives(int c, int r);
        int n;
        int nc;
        int nr;
        n = 0;
        nc = used_cols();
        nr = used_rows();
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (!(dr == 0 && dc == 0) && r + dr >= 0 && c + dc >= 0 &&
                    r + dr < nr && c + dc < nc && grid_alive[r+dr][c+dc])
                    n++;
        return grid_alive[r][c] ? (n == 2 || n == 3) : (n == 3);
    endfunction

    function automatic void advance_generation();
        logic next_alive [MAX_ROWS][MAX_COLS];
        bit live;
        next_alive = grid_alive;
        for (int r = 0; r < used_rows(); r++)
            for (int c = 0; c < used_cols(); c++) begin
                live = survives(c, r);
                if (grid_alive[r][c]) begin
                    if (live) begin
                        if (grid_age[r][c] != AGE_MAX) grid_age[r][c]++;
                        if (grid_age[r][c] >= green_reg) grid_color[r][c] = COLOR_GREEN;
                    end
                end else begin
                    if (live) grid_age[r][c] = '0;
                    grid_color[r][c] = COLOR_BLACK;
                end
                next_alive[r][c] = live;
            end
        grid_alive = next_alive;
    endfunction

    // predict the result of one request and update the shadow
    function automatic cell_report_t predict_request(logic [OP_W-1:0] op, int c, int r,
                                                     logic v);
        cell_report_t rep;
        bit in_area;
        rep = '0;
        in_area = c < used_cols() && r < used_rows();
        case (op)
            OP_STEP: advance_generation();
            OP_SET: if (in_area) grid_alive[r][c] = v;
            OP_TOGGLE: if (in_area) grid_alive[r][c] = !grid_alive[r][c];
            OP_QUERY: if (in_area) begin
                rep.alive = grid_alive[r][c];
                rep.dying = !survives(c, r);
                rep.age = grid_age[r][c];
                rep.color = grid_color[r][c];
            end
            OP_CLEAR: begin
                foreach (grid_alive[i, j]) begin
                    grid_alive[i][j] = 1'b0;
                    grid_color[i][j] = COLOR_WHITE;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    task automatic wait_idle_gap();
        if (!calm_sink && $urandom_range(99) < 7)
            repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    // the block is never ready in the cycle after an accept, so the leading
    // edge costs no throughput
    task automatic send_request(logic [OP_W-1:0] op, int c, int r, logic v);
        int cw;
        int rw;
        cw = int'(c[COL_W-1:0]);
        rw = int'(r[ROW_W-1:0]);
        @(posedge aclk);
        wait_idle_gap();
        s_valid <= 1'b1;
        s_operation <= op;
        s_col <= c[COL_W-1:0];
        s_row <= r[ROW_W-1:0];
        s_new_alive <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_reports.push_back(predict_request(op, cw, rw, v));
        if (op == OP_QUERY) query_count++;
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COLS: width_reg = value[CNT_W-1:0];
            REG_ROWS: height_reg = value[CNT_W-1:0];
            default:  green_reg = value[AGE_W-1:0];
        endcase
    endtask

    // result checker
    always @(posedge aclk) begin
        cell_report_t want;
        if (aresetn && m_valid && m_ready) begin
            report_count++;
            if (pending_reports.size() == 0) begin
                $display("t=%0t unexpected result", $time);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (want !== {m_cell_alive, m_cell_dying, m_cell_age, m_cell_color}) begin
                    $display("t=%0t mismatch exp alive=%0d dying=%0d age=%0d color=%0d",
                             $time, want.alive, want.dying, want.age, want.color);
                    $display("    act alive=%0d dying=%0d age=%0d color=%0d",
                             m_cell_alive, m_cell_dying, m_cell_age, m_cell_color);
                    fail_count++;
                end
            end
        end
    end

    // result-side stall
    always @(posedge aclk) begin
        m_ready <= calm_sink || $urandom_range(99) >= 7;
    end

    task automatic query_area(int nc, int nr);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) send_request(OP_QUERY, c, r, 1'b0);
    endtask

    // directed: corners, edit ops, a step, a clear and unknown codes on a full grid
    task automatic test_directed_edits();
        send_request(OP_QUERY, 63, 63, 1'b0);
        send_request(OP_SET, 0, 0, 1'b1);
        send_request(OP_SET, 63, 63, 1'b1);
        send_request(OP_TOGGLE, 63, 0, 1'b0);
        send_request(OP_TOGGLE, 63, 0, 1'b0);
        send_request(OP_SET, 0, 0, 1'b0);
        send_request(OP_SET, 0, 0, 1'b1);
        send_request(OP_QUERY, 0, 0, 1'b0);
        send_request(OP_QUERY, 63, 63, 1'b0);
        send_request(OP_BAD, 5, 5, 1'b1);
        send_request(3'd5, 63, 0, 1'b0);
        send_request(OP_STEP, 0, 0, 1'b0);
        send_request(OP_QUERY, 0, 0, 1'b0);
        send_request(OP_CLEAR, 0, 0, 1'b0);
        send_request(OP_QUERY, 63, 63, 1'b0);
        drain_results();
    endtask

    // small grid: blinker, saturation-free ageing and green threshold
    task automatic test_small_patterns();
        write_register(REG_COLS, 5);
        write_register(REG_ROWS, 5);
        write_register(REG_GREEN, 2);
        send_request(OP_SET, 1, 2, 1'b1);
        send_request(OP_SET, 2, 2, 1'b1);
        send_request(OP_SET, 3, 2, 1'b1);
        send_request(OP_SET, 9, 1, 1'b1);   // outside area: ignored
        send_request(OP_QUERY, 9, 1, 1'b0);
        repeat (3) send_request(OP_STEP, 0, 0, 1'b0);
        query_area(5, 1);
        send_request(OP_QUERY, 2, 2, 1'b0);
        drain_results();
        // zero and oversized counts
        write_register(REG_COLS, 0);
        write_register(REG_ROWS, 127);
        write_register(REG_GREEN, 0);
        send_request(OP_SET, 0, 3, 1'b1);
        send_request(OP_STEP, 0, 0, 1'b0);
        send_request(OP_QUERY, 0, 3, 1'b0);
        send_request(OP_QUERY, 1, 3, 1'b0);
        drain_results();
        write_register(REG_GREEN, 65535);
    endtask

    // random: mostly seeded small boards with steps and queries, some noise
    task automatic test_random_boards();
        int nc;
        int nr;
        int r;
        for (int round = 0; round < 6; round++) begin
            nc = (round == 5) ? 64 : $urandom_range(3, 8);
            nr = (round == 5) ? 64 : $urandom_range(3, 8);
            write_register(REG_COLS, nc);
            write_register(REG_ROWS, nr);
            write_register(REG_GREEN, $urandom_range(0, 4));
            calm_sink = (round == 2);
            repeat (20) begin
                r = $urandom_range(99);
                if (r < 35)
                    send_request(OP_SET, $urandom_range(nc - 1), $urandom_range(nr - 1),
                                 1'($urandom_range(1)));
                else if (r < 45)
                    send_request(OP_TOGGLE, $urandom_range(63), $urandom_range(63), 1'b0);
                else if (r < 60)
                    send_request(OP_STEP, $urandom_range(63), $urandom_range(63),
                                 1'($urandom_range(1)));
                else if (r < 94)
                    send_request(OP_QUERY, $urandom_range(nc), $urandom_range(nr), 1'b0);
                else if (r < 97)
                    send_request(OP_W'($urandom_range(5, 7)), $urandom_range(63),
                                 $urandom_range(63), 1'($urandom_range(1)));
                else
                    send_request(OP_CLEAR, 0, 0, 1'b0);
            end
            calm_sink = 1'b0;
            // sender holds off until all results are in
            drain_results();
        end
    endtask

    initial begin
        foreach (grid_alive[i, j]) begin
            grid_alive[i][j] = 1'b0;
            grid_age[i][j] = '0;
            grid_color[i][j] = COLOR_WHITE;
        end
        width_reg = 7'd64;
        height_reg = 7'd64;
        green_reg = 16'd200;
        fail_count = 0;
        report_count = 0;
        query_count = 0;
        cycle_count = 0;
        calm_sink = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_edits();
        test_small_patterns();
        test_random_boards();
        drain_results();
        $display("covered %0d results (%0d queries): edits, steps, clears, bad codes,",
                 report_count, query_count);
        $display("register extremes and small to full grids");
        if (fail_count == 0)
            $display("life_automaton_with_cell_age regression: pass");
        else
            $display("life_automaton_with_cell_age regression: fail");
        $finish;
    end

endmodule
